[sv/hashed_pair_sum_matcher_assert.svh]
// ----------------------------------------------------------------------------
// Hashed pair-sum matcher: assertion macros
// Shared property wrappers on the block clock with the synchronous reset.
// ----------------------------------------------------------------------------
`ifndef HASHED_PAIR_SUM_MATCHER_ASSERT_SVH
`define HASHED_PAIR_SUM_MATCHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPSM_CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HPSM_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/hpsm_pkg.sv]
// ----------------------------------------------------------------------------
// Hashed pair-sum matcher: package
// Sizes, table row layout, outcome codes, state encoding and the bucket hash.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpsm_pkg;

    // Table geometry: the bucket count is a power of two.
    localparam int unsigned BUCKET_W  = 8;
    localparam int unsigned BUCKETS   = 1 << BUCKET_W;
    localparam int unsigned WAYS      = 4;
    localparam int unsigned MAX_ITEMS = 1024;

    localparam int unsigned NUM_W     = 32;
    localparam int unsigned POS_W     = $clog2(MAX_ITEMS) + 1;
    localparam int unsigned EPOS_W    = $clog2(MAX_ITEMS);
    localparam int unsigned CNT_W     = $clog2(WAYS + 1);
    localparam int unsigned OUT_POS_W = 10;

    typedef logic [NUM_W-1:0]     t_num;
    typedef logic [POS_W-1:0]     t_pos;
    typedef logic [EPOS_W-1:0]    t_epos;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [BUCKET_W-1:0]  t_bucket;
    typedef logic [OUT_POS_W-1:0] t_out_pos;

    // One bucket: keys and positions of its ways, plus the number of ways in use.
    typedef struct packed {
        logic [WAYS-1:0][NUM_W-1:0]  key;
        logic [WAYS-1:0][EPOS_W-1:0] pos;
        t_cnt                        cnt;
    } t_row;

    // Requests from the control to the table.
    typedef struct packed {
        logic    rd_en;
        t_bucket rd_addr;
        logic    wr_en;
        t_bucket wr_addr;
        logic    clear;
    } t_tbl_req;

    // Result of scanning one bucket row.
    typedef struct packed {
        logic  hit;
        t_epos hit_pos;
        t_cnt  count;
    } t_look;

    typedef enum logic [1:0] {
        OUT_PAIR = 2'd0,
        OUT_NONE = 2'd1,
        OUT_OVFL = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_INSERT,
        S_EMIT
    } t_state;

    // Bucket of a 33-bit signed key: low bits of its magnitude.
    function automatic t_bucket bucket_of(input logic [NUM_W:0] key);
        t_bucket low;
        low = key[BUCKET_W-1:0];
        return key[NUM_W] ? t_bucket'(~low + t_bucket'(1)) : low;
    endfunction

endpackage

[sv/hashed_pair_sum_matcher.sv]
// ----------------------------------------------------------------------------
// Hashed pair-sum matcher: top level
// Finds the first pair of numbers in a set that adds up to the target sum,
// using a bucketed hash table of earlier numbers and their positions.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_ready    i_number, i_first_of_set,
//                                                   i_last_of_set
//   result    out        o_out_valid / i_out_ready  o_outcome,
//                                                   o_earlier_position,
//                                                   o_later_position
//   config    in         i_cfg_wr_en                i_cfg_wr_data (target sum)
//
// A stored number goes through accept with the complement bucket read, then
// the number bucket read and write back; both reads use the table read port.
// A result is staged on accept (position overflow), in lookup (hit) or in
// insert (no pair, full bucket); emit then moves it to the output register.
// A request after the set has ended is dropped in its accept cycle.
// The output register lets the block finish a result while the previous one
// is still waiting; a further result waits until that register is free.
// After reset the table is empty at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hashed_pair_sum_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_number,
    input  logic        i_first_of_set,
    input  logic        i_last_of_set,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_outcome,
    output logic [9:0]  o_earlier_position,
    output logic [9:0]  o_later_position
);

    hpsm_pkg::t_state   r_state, n_state;
    hpsm_pkg::t_num     r_target;
    hpsm_pkg::t_pos     r_pos, n_pos;
    logic               r_set_done, n_set_done;
    hpsm_pkg::t_num     r_num, n_num;
    logic               r_last, n_last;
    hpsm_pkg::t_num     r_ckey, n_ckey;
    logic               r_ckey_ok, n_ckey_ok;
    hpsm_pkg::t_bucket  r_nbucket, n_nbucket;
    hpsm_pkg::t_outcome r_res_outcome, n_res_outcome;
    hpsm_pkg::t_epos    r_res_early, n_res_early;
    hpsm_pkg::t_epos    r_res_late, n_res_late;
    logic               r_out_valid, n_out_valid;
    hpsm_pkg::t_outcome r_out_outcome, n_out_outcome;
    hpsm_pkg::t_epos    r_out_early, n_out_early;
    hpsm_pkg::t_epos    r_out_late, n_out_late;

    hpsm_pkg::t_tbl_req tbl_req;
    hpsm_pkg::t_row     rd_row;
    hpsm_pkg::t_row     wr_row;
    logic               rd_live;
    hpsm_pkg::t_look    look;

    logic                  in_acc;
    logic                  out_free;
    logic                  eff_done;
    hpsm_pkg::t_pos        eff_pos;
    logic                  eff_ovf;
    logic [hpsm_pkg::NUM_W:0] comp;
    logic                  full;

    assign o_in_ready = (r_state == hpsm_pkg::S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // A first item reopens the set before it is processed.
    assign eff_done = i_first_of_set ? 1'b0 : r_set_done;
    assign eff_pos  = i_first_of_set ? '0 : r_pos;
    assign eff_ovf  = (eff_pos >= hpsm_pkg::t_pos'(hpsm_pkg::MAX_ITEMS));

    // Complement at 33 bits; it can only match when it fits in 32 bits.
    assign comp = {r_target[hpsm_pkg::NUM_W-1], r_target}
                - {i_number[hpsm_pkg::NUM_W-1], i_number};

    assign full = (look.count == hpsm_pkg::t_cnt'(hpsm_pkg::WAYS));

    hpsm_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (tbl_req),
        .i_wr_row (wr_row),
        .o_rd_row (rd_row),
        .o_rd_live(rd_live)
    );

    hpsm_lookup u_lookup (
        .i_row   (rd_row),
        .i_live  (rd_live),
        .i_key   (r_ckey),
        .i_key_ok(r_ckey_ok),
        .o_look  (look)
    );

    // Write-back row: the number and its position go into the first free way.
    always_comb begin
        wr_row     = rd_row;
        wr_row.cnt = look.count + hpsm_pkg::t_cnt'(1);
        for (int w = 0; w < hpsm_pkg::WAYS; w++) begin
            if (look.count == hpsm_pkg::t_cnt'(w)) begin
                wr_row.key[w] = r_num;
                wr_row.pos[w] = r_pos[hpsm_pkg::EPOS_W-1:0];
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            hpsm_pkg::S_IDLE: begin
                if (in_acc && !eff_done) begin
                    n_state = eff_ovf ? hpsm_pkg::S_EMIT : hpsm_pkg::S_LOOKUP;
                end
            end
            hpsm_pkg::S_LOOKUP: begin
                n_state = look.hit ? hpsm_pkg::S_EMIT : hpsm_pkg::S_INSERT;
            end
            hpsm_pkg::S_INSERT: begin
                n_state = (full || r_last) ? hpsm_pkg::S_EMIT : hpsm_pkg::S_IDLE;
            end
            hpsm_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = hpsm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hpsm_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, table requests and result staging.
    always_comb begin
        tbl_req       = '0;
        n_pos         = r_pos;
        n_set_done    = r_set_done;
        n_num         = r_num;
        n_last        = r_last;
        n_ckey        = r_ckey;
        n_ckey_ok     = r_ckey_ok;
        n_nbucket     = r_nbucket;
        n_res_outcome = r_res_outcome;
        n_res_early   = r_res_early;
        n_res_late    = r_res_late;
        case (r_state)
            hpsm_pkg::S_IDLE: begin
                if (in_acc) begin
                    tbl_req.clear = i_first_of_set;
                    n_set_done    = eff_done;
                    n_pos         = eff_pos;
                    n_num         = i_number;
                    n_last        = i_last_of_set;
                    n_ckey        = comp[hpsm_pkg::NUM_W-1:0];
                    n_ckey_ok     = (comp[hpsm_pkg::NUM_W] == comp[hpsm_pkg::NUM_W-1]);
                    n_nbucket     = hpsm_pkg::bucket_of({i_number[hpsm_pkg::NUM_W-1],
                                                         i_number});
                    if (!eff_done) begin
                        if (eff_ovf) begin
                            n_set_done    = 1'b1;
                            n_res_outcome = hpsm_pkg::OUT_OVFL;
                            n_res_early   = '0;
                            n_res_late    = '0;
                        end else begin
                            tbl_req.rd_en   = 1'b1;
                            tbl_req.rd_addr = hpsm_pkg::bucket_of(comp);
                        end
                    end
                end
            end
            hpsm_pkg::S_LOOKUP: begin
                if (look.hit) begin
                    n_set_done    = 1'b1;
                    n_res_outcome = hpsm_pkg::OUT_PAIR;
                    n_res_early   = look.hit_pos;
                    n_res_late    = r_pos[hpsm_pkg::EPOS_W-1:0];
                end else begin
                    tbl_req.rd_en   = 1'b1;
                    tbl_req.rd_addr = r_nbucket;
                end
            end
            hpsm_pkg::S_INSERT: begin
                if (full) begin
                    n_set_done    = 1'b1;
                    n_res_outcome = hpsm_pkg::OUT_OVFL;
                    n_res_early   = '0;
                    n_res_late    = '0;
                end else begin
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_addr = r_nbucket;
                    n_pos           = r_pos + hpsm_pkg::t_pos'(1);
                    if (r_last) begin
                        n_set_done    = 1'b1;
                        n_res_outcome = hpsm_pkg::OUT_NONE;
                        n_res_early   = '0;
                        n_res_late    = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: loads the staged result once the previous one is taken.
    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_outcome = r_out_outcome;
        n_out_early   = r_out_early;
        n_out_late    = r_out_late;
        if ((r_state == hpsm_pkg::S_EMIT) && out_free) begin
            n_out_valid   = 1'b1;
            n_out_outcome = r_res_outcome;
            n_out_early   = r_res_early;
            n_out_late    = r_res_late;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hpsm_pkg::S_IDLE;
            r_target    <= '0;
            r_pos       <= '0;
            r_set_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_set_done  <= n_set_done;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_target <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_num         <= n_num;
        r_last        <= n_last;
        r_ckey        <= n_ckey;
        r_ckey_ok     <= n_ckey_ok;
        r_nbucket     <= n_nbucket;
        r_res_outcome <= n_res_outcome;
        r_res_early   <= n_res_early;
        r_res_late    <= n_res_late;
        r_out_outcome <= n_out_outcome;
        r_out_early   <= n_out_early;
        r_out_late    <= n_out_late;
    end

    assign o_out_valid        = r_out_valid;
    assign o_outcome          = r_out_outcome;
    assign o_earlier_position = hpsm_pkg::t_out_pos'(r_out_early);
    assign o_later_position   = hpsm_pkg::t_out_pos'(r_out_late);

    // Checks on the control flow.
    `include "hashed_pair_sum_matcher_assert.svh"

    `HPSM_CHK_SAME(a_load_from_emit, $rose(o_out_valid), $past(r_state) == hpsm_pkg::S_EMIT, "result loaded outside the emit state")
    `HPSM_CHK_SAME(a_emit_ends_set, r_state == hpsm_pkg::S_EMIT, r_set_done, "result pending while the set is still open")
    `HPSM_CHK_SAME(a_pair_order, o_out_valid && (o_outcome == hpsm_pkg::OUT_PAIR), o_earlier_position < o_later_position, "pair positions out of order")
    `HPSM_CHK_NEXT(a_insert_counts, tbl_req.wr_en, r_pos != '0, "position not advanced after a store")

endmodule

[sv/hpsm_table.sv]
// ----------------------------------------------------------------------------
// Hashed pair-sum matcher: bucket table
// One row per bucket in a synchronous memory, with a live flag per row that
// is cleared at once when a new set starts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpsm_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hpsm_pkg::t_tbl_req i_req,
    input  hpsm_pkg::t_row     i_wr_row,
    output hpsm_pkg::t_row     o_rd_row,
    output logic               o_rd_live
);

    hpsm_pkg::t_row             r_mem [hpsm_pkg::BUCKETS];
    logic [hpsm_pkg::BUCKETS-1:0] r_live;
    hpsm_pkg::t_row             r_rd_row;
    logic                       r_rd_live;

    // Row storage: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_wr_row;
        end
        if (i_req.rd_en) begin
            r_rd_row <= r_mem[i_req.rd_addr];
        end
    end

    // Live flags: a row that is not live holds no valid ways.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= '0;
            r_rd_live <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_live <= '0;
            end else if (i_req.wr_en) begin
                r_live[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_live <= i_req.clear ? 1'b0 : r_live[i_req.rd_addr];
            end
        end
    end

    assign o_rd_row  = r_rd_row;
    assign o_rd_live = r_rd_live;

endmodule

[sv/hpsm_lookup.sv]
// ----------------------------------------------------------------------------
// Hashed pair-sum matcher: row scan
// Compares a key against the used ways of one row and reports the newest
// match and the fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpsm_lookup (
    input  hpsm_pkg::t_row  i_row,
    input  logic            i_live,
    input  hpsm_pkg::t_num  i_key,
    input  logic            i_key_ok,
    output hpsm_pkg::t_look o_look
);

    hpsm_pkg::t_cnt count;

    // A row that is not live counts as empty.
    assign count = i_live ? i_row.cnt : '0;

    // Ways fill in order, so the highest matching way is the newest one.
    always_comb begin
        o_look       = '0;
        o_look.count = count;
        for (int w = 0; w < hpsm_pkg::WAYS; w++) begin
            if ((hpsm_pkg::t_cnt'(w) < count) && (i_row.key[w] == i_key)) begin
                o_look.hit     = i_key_ok;
                o_look.hit_pos = i_row.pos[w];
            end
        end
    end

endmodule

[tb/hashed_pair_sum_matcher_test.sv]
// ----------------------------------------------------------------------------
// Hashed pair-sum matcher: testbench
// Feeds sets of signed numbers through the request channel and predicts each
// result with an independent model of the bucketed table. A short table of
// directed requests covers the corner cases, a long set fills the table
// until the position limit trips, and random sets with random target sums
// follow. Both channels idle and stall at random until the closing stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hashed_pair_sum_matcher_test;
    import hpsm_pkg::*;

    localparam int RANDOM_ITEMS  = 700;
    localparam int CALM_ITEMS    = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int TIME_LIMIT_NS = 1000000;
    localparam int SLOTS         = BUCKETS * WAYS;

    typedef struct packed {
        t_outcome outcome;
        t_out_pos early;
        t_out_pos late;
    } pair_report_t;

    // One directed request, with an optional target write ahead of it and an
    // optional hand-typed expectation.
    typedef struct {
        bit       set_target;
        t_num     target;
        t_num     number;
        bit       first;
        bit       last;
        bit       typed;
        bit       has_res;
        t_outcome outcome;
        t_out_pos early;
        t_out_pos late;
    } stim_row_t;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_wr_en    = 1'b0;
    logic [31:0] i_cfg_wr_data  = '0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    t_num        i_number       = '0;
    logic        i_first_of_set = 1'b0;
    logic        i_last_of_set  = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [1:0]  o_outcome;
    logic [9:0]  o_earlier_position;
    logic [9:0]  o_later_position;

    // Predictor state: target register and the table of earlier numbers.
    t_num     target_sum_q = '0;
    bit       seen_valid [SLOTS];
    t_num     seen_key   [SLOTS];
    t_out_pos seen_pos   [SLOTS];
    int       set_position = 0;
    bit       set_closed   = 1'b0;

    pair_report_t reports_due[$];
    pair_report_t head_report;
    pair_report_t blank_report = '0;
    t_num         set_members[$];
    int           fault_count   = 0;
    int           served        = 0;
    int           stall_left    = 0;
    bit           gap_requests  = 1'b0;
    bit           stall_results = 1'b0;

    stim_row_t directed_rows[22] = '{
        // Reset target of zero, no start flag after reset.
        '{1'b0, 32'h0, 32'd7,          1'b0, 1'b0, 1'b1, 1'b0, OUT_PAIR, 10'd0, 10'd0},
        '{1'b0, 32'h0, 32'hFFFF_FFF9,  1'b0, 1'b0, 1'b1, 1'b1, OUT_PAIR, 10'd0, 10'd1},
        // The set has ended, so this request is dropped.
        '{1'b0, 32'h0, 32'd3,          1'b0, 1'b1, 1'b1, 1'b0, OUT_PAIR, 10'd0, 10'd0},
        // Two equal keys: the newer one must be reported.
        '{1'b0, 32'h0, 32'd5,          1'b1, 1'b0, 1'b1, 1'b0, OUT_PAIR, 10'd0, 10'd0},
        '{1'b0, 32'h0, 32'd5,          1'b0, 1'b0, 1'b1, 1'b0, OUT_PAIR, 10'd0, 10'd0},
        '{1'b0, 32'h0, 32'hFFFF_FFFB,  1'b0, 1'b0, 1'b1, 1'b1, OUT_PAIR, 10'd1, 10'd2},
        // Five keys in one bucket, the fifth on the last request.
        '{1'b0, 32'h0, 32'd1,          1'b1, 1'b0, 1'b1, 1'b0, OUT_PAIR, 10'd0, 10'd0},
        '{1'b0, 32'h0, 32'd257,        1'b0, 1'b0, 1'b1, 1'b0, OUT_PAIR, 10'd0, 10'd0},
        '{1'b0, 32'h0, 32'd513,        1'b0, 1'b0, 1'b1, 1'b0, OUT_PAIR, 10'd0, 10'd0},
        '{1'b0, 32'h0, 32'd769,        1'b0, 1'b0, 1'b1, 1'b0, OUT_PAIR, 10'd0, 10'd0},
        '{1'b0, 32'h0, 32'd1025,       1'b0, 1'b1, 1'b1, 1'b1, OUT_OVFL, 10'd0, 10'd0},
        '{1'b0, 32'h0, 32'd0,          1'b1, 1'b1, 1'b1, 1'b1, OUT_NONE, 10'd0, 10'd0},
        // Largest target: complements beyond 32 bits must not wrap into a hit.
        '{1'b1, 32'h7FFF_FFFF, 32'h8000_0000,
                                       1'b1, 1'b0, 1'b1, 1'b0, OUT_PAIR, 10'd0, 10'd0},
        '{1'b0, 32'h0, 32'hFFFF_FFFF,  1'b0, 1'b0, 1'b1, 1'b0, OUT_PAIR, 10'd0, 10'd0},
        '{1'b0, 32'h0, 32'h7FFF_FFFF,  1'b0, 1'b0, 1'b1, 1'b0, OUT_PAIR, 10'd0, 10'd0},
        '{1'b0, 32'h0, 32'd0,          1'b0, 1'b1, 1'b1, 1'b1, OUT_PAIR, 10'd2, 10'd3},
        // Smallest target.
        '{1'b1, 32'h8000_0000, 32'd1,  1'b1, 1'b0, 1'b1, 1'b0, OUT_PAIR, 10'd0, 10'd0},
        '{1'b0, 32'h0, 32'h8000_0000,  1'b0, 1'b0, 1'b1, 1'b0, OUT_PAIR, 10'd0, 10'd0},
        '{1'b0, 32'h0, 32'd0,          1'b0, 1'b1, 1'b1, 1'b1, OUT_PAIR, 10'd1, 10'd2},
        // Ordinary target, left to the predictor.
        '{1'b1, 32'h55AA_33CC, 32'h1234_5678,
                                       1'b1, 1'b0, 1'b0, 1'b0, OUT_PAIR, 10'd0, 10'd0},
        '{1'b0, 32'h0, 32'h4375_DD54,  1'b0, 1'b0, 1'b0, 1'b0, OUT_PAIR, 10'd0, 10'd0},
        '{1'b0, 32'h0, 32'hDEAD_BEEF,  1'b1, 1'b1, 1'b0, 1'b0, OUT_PAIR, 10'd0, 10'd0}
    };

    hashed_pair_sum_matcher dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_number           (i_number),
        .i_first_of_set     (i_first_of_set),
        .i_last_of_set      (i_last_of_set),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_outcome          (o_outcome),
        .o_earlier_position (o_earlier_position),
        .o_later_position   (o_later_position)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bucket of a signed key: its magnitude modulo the bucket count.
    function automatic int hash_bucket(input logic signed [33:0] key);
        logic signed [33:0] mag;
        mag = (key < 0) ? -key : key;
        return int'(mag % BUCKETS);
    endfunction

    // Works out the result of one accepted request and updates the table.
    function automatic bit predict_report(input t_num num, input bit first, input bit last,
                                          output pair_report_t rep, output bit ignored);
        logic signed [33:0] wide_num;
        logic signed [33:0] wide_target;
        logic signed [33:0] comp;
        int base;
        int w;
        rep = blank_report;
        ignored = 1'b0;
        if (first) begin
            foreach (seen_valid[i]) seen_valid[i] = 1'b0;
            set_position = 0;
            set_closed = 1'b0;
        end
        if (set_closed) begin
            ignored = 1'b1;
            return 1'b0;
        end
        if (set_position >= MAX_ITEMS) begin
            set_closed = 1'b1;
            rep.outcome = OUT_OVFL;
            return 1'b1;
        end
        wide_num = $signed(num);
        wide_target = $signed(target_sum_q);
        comp = wide_target - wide_num;
        // A complement outside the 32-bit range can never be a stored key.
        if (comp[33:31] == 3'b000 || comp[33:31] == 3'b111) begin
            base = hash_bucket(comp) * WAYS;
            for (w = int'(WAYS) - 1; w >= 0; w--) begin
                if (seen_valid[base + w] && seen_key[base + w] == comp[31:0]) begin
                    set_closed = 1'b1;
                    rep.outcome = OUT_PAIR;
                    rep.early = seen_pos[base + w];
                    rep.late = t_out_pos'(set_position);
                    return 1'b1;
                end
            end
        end
        // Miss: take the first free way of the number's own bucket.
        base = hash_bucket(wide_num) * WAYS;
        w = 0;
        while (w < WAYS && seen_valid[base + w]) w++;
        if (w == WAYS) begin
            set_closed = 1'b1;
            rep.outcome = OUT_OVFL;
            return 1'b1;
        end
        seen_valid[base + w] = 1'b1;
        seen_key[base + w] = num;
        seen_pos[base + w] = t_out_pos'(set_position);
        set_position++;
        if (last) begin
            set_closed = 1'b1;
            rep.outcome = OUT_NONE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Drives one request, waits for it to be taken and queues its result.
    task automatic offer_request(input t_num num, input bit first, input bit last,
                                 input bit typed, input bit typed_has,
                                 input pair_report_t typed_rep);
        pair_report_t rep;
        bit produced;
        bit ignored;
        if (gap_requests && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_number <= num;
        i_first_of_set <= first;
        i_last_of_set <= last;
        do @(posedge i_clk); while (!o_in_ready);
        produced = predict_report(num, first, last, rep, ignored);
        if (typed) begin
            produced = typed_has;
            rep = typed_rep;
        end
        if (produced) reports_due.push_back(rep);
        if (!ignored) served++;
    endtask

    // The target is only written once the block has gone quiet.
    task automatic write_target(input t_num value);
        i_in_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        target_sum_q = value;
    endtask

    // Picks a set member, biased towards hits, repeats and shared buckets.
    function automatic t_num pick_member();
        t_num seen;
        if (set_members.size() != 0)
            seen = set_members[$urandom_range(0, set_members.size() - 1)];
        else
            seen = t_num'($urandom);
        case ($urandom_range(0, 11))
            0, 1, 2: return target_sum_q - seen;
            3:       return seen;
            4:       return seen + (t_num'($urandom_range(1, 8)) << 8);
            5:       return -seen;
            6, 7:    return t_num'($urandom_range(0, 40)) - 32'd20;
            8:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return t_num'($urandom);
        endcase
    endfunction

    // One random set: mostly well formed, sometimes packed into one bucket,
    // sometimes with missing or stray start and end flags.
    task automatic run_random_set();
        int len;
        int shape;
        int i;
        bit first;
        bit last;
        t_num num;
        logic [7:0] low_byte;
        shape = $urandom_range(0, 9);
        if (shape == 7)
            len = $urandom_range(4, 7);
        else if ($urandom_range(0, 9) == 0)
            len = $urandom_range(13, 40);
        else
            len = $urandom_range(1, 12);
        low_byte = 8'($urandom);
        set_members.delete();
        for (i = 0; i < len; i++) begin
            first = (i == 0);
            last = (i == len - 1);
            case (shape)
                7: num = {1'b0, 23'($urandom), low_byte};
                8: begin
                    first = (i != 0) && ($urandom_range(0, 15) == 0);
                    last = last && ($urandom_range(0, 1) == 1);
                    num = pick_member();
                end
                9: begin
                    first = ($urandom_range(0, 7) == 0);
                    last = ($urandom_range(0, 3) == 0);
                    num = t_num'($urandom);
                end
                default: num = pick_member();
            endcase
            set_members.push_back(num);
            offer_request(num, first, last, 1'b0, 1'b0, blank_report);
        end
    endtask

    // Result side stalls in bursts of random length.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (stall_results && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Each taken result is compared with the oldest one predicted.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (reports_due.size() == 0) begin
                $error("outcome: expected no result, actual %0d", o_outcome);
                fault_count++;
            end else begin
                head_report = reports_due.pop_front();
                if (o_outcome !== head_report.outcome) begin
                    $error("outcome: expected %0d, actual %0d", head_report.outcome, o_outcome);
                    fault_count++;
                end
                if (o_earlier_position !== head_report.early) begin
                    $error("earlier_position: expected %0d, actual %0d",
                           head_report.early, o_earlier_position);
                    fault_count++;
                end
                if (o_later_position !== head_report.late) begin
                    $error("later_position: expected %0d, actual %0d",
                           head_report.late, o_later_position);
                    fault_count++;
                end
            end
        end
    end

    initial begin
        int n;
        int guard;
        t_num target;
        pair_report_t row_rep;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gap_requests = 1'b1;
        stall_results = 1'b1;

        // Directed requests from the table.
        foreach (directed_rows[r]) begin
            if (directed_rows[r].set_target) write_target(directed_rows[r].target);
            row_rep.outcome = directed_rows[r].outcome;
            row_rep.early = directed_rows[r].early;
            row_rep.late = directed_rows[r].late;
            offer_request(directed_rows[r].number, directed_rows[r].first,
                          directed_rows[r].last, directed_rows[r].typed,
                          directed_rows[r].has_res, row_rep);
        end

        // Fill every way of every bucket, then one request past the position limit.
        write_target('0);
        for (n = 1; n <= MAX_ITEMS + 1; n++)
            offer_request(t_num'(n), n == 1, n == MAX_ITEMS + 1, 1'b0, 1'b0, blank_report);

        // Random phases, each with its own target sum.
        served = 0;
        while (served < RANDOM_ITEMS) begin
            case ($urandom_range(0, 4))
                0:       target = '0;
                1:       target = 32'h7FFF_FFFF;
                2:       target = 32'h8000_0000;
                default: target = t_num'($urandom);
            endcase
            write_target(target);
            gap_requests = ($urandom_range(0, 3) != 0);
            stall_results = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 6)) begin
                if (served > RANDOM_ITEMS - CALM_ITEMS) begin
                    gap_requests = 1'b0;
                    stall_results = 1'b0;
                end
                run_random_set();
            end
        end

        i_in_valid <= 1'b0;
        guard = 0;
        while (reports_due.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (reports_due.size() != 0) begin
            $error("outcome: %0d expected results never arrived", reports_due.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIME_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
